// ===== sv/rsps_pkg.sv =====
`timescale 1ns / 1ps
package rsps_pkg;

  // Q4.16 operand format
  localparam int FRAC = 16;
  localparam int QW   = 20;

  localparam logic signed [31:0] SAT_HI = 32'sd524287;
  localparam logic signed [31:0] SAT_LO = -32'sd524288;
  localparam logic signed [31:0] ONE_S  = 32'sd65536;

  localparam logic [16:0] ONE    = 17'h10000;
  localparam logic [14:0] K03    = 15'((64'd3 << 16) / 64'd10);
  localparam logic [24:0] SCALE  = 25'((64'd255999 << 16) / 64'd1000);
  localparam logic [39:0] DZ_SQ  = 40'h01_0000_0000;

  // sky path widths
  localparam int LSQ_W  = 40;
  localparam int LEN_W  = 20;
  localparam int SQ_STG = 20;
  localparam int QUO_W  = 17;

  typedef enum logic [2:0] {
    REG_SPHERE_X,
    REG_SPHERE_Y,
    REG_SPHERE_Z,
    REG_SPHERE_RADIUS,
    REG_CORNER_X,
    REG_CORNER_Y,
    REG_STEP_X,
    REG_STEP_Y
  } reg_idx_t;

  typedef struct packed {
    logic signed [19:0] sphere_x;
    logic signed [19:0] sphere_y;
    logic signed [19:0] sphere_z;
    logic        [18:0] sphere_radius;
    logic signed [19:0] corner_x;
    logic signed [19:0] corner_y;
    logic signed [19:0] step_x;
    logic signed [19:0] step_y;
  } cfg_t;

  // classified ray handed from front to back
  typedef struct packed {
    logic               hit;
    logic signed [19:0] dy;
    logic [LSQ_W-1:0]   lsq;
  } ray_t;

  // per-pixel data riding along the sky pipeline
  typedef struct packed {
    logic        hit;
    logic        neg;
    logic [19:0] mag;
  } tag_t;

  // clamp to the Q4.16 range
  function automatic logic signed [19:0] sat_q(input logic signed [31:0] x);
    logic signed [31:0] r;
    begin
      if (x > SAT_HI) r = SAT_HI;
      else if (x < SAT_LO) r = SAT_LO;
      else r = x;
      return r[19:0];
    end
  endfunction

endpackage

// ===== sv/rsps_front.sv =====
`timescale 1ns / 1ps
module rsps_front #(
  parameter int MAX_DIM = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  rsps_pkg::cfg_t cfg,
  input  logic           in_valid,
  input  logic [9:0]     row,
  input  logic [9:0]     col,
  input  logic           q_full,
  output logic           push,
  output rsps_pkg::ray_t ray
);

  localparam logic [12:0] DIM_LAST = 13'(MAX_DIM - 1);

  logic en;
  logic v1, v2, v3, v4, v5, v6;

  logic [9:0] row1, col1;
  logic signed [30:0] px2, py2;
  logic signed [19:0] dx3, dy3, dy4, dy5, dy6;
  logic signed [39:0] dxdx4, dydy4, dxox4, dyoy4, oxox4, oyoy4, ozoz4;
  logic [37:0] rr4;
  logic signed [19:0] oz4;
  logic signed [19:0] a5, b5, c5;
  logic [39:0] lsq5, lsq6;
  logic signed [39:0] bbp6, acp6;

  logic signed [30:0] colx, rowx, stx, sty;
  logic signed [19:0] ox, oy, oz;
  logic signed [39:0] edx, edy, eox, eoy, eoz, ea, eb, ec;
  logic signed [25:0] bbx, fac;

  assign en = !q_full;

  // stage 1: clamp indices
  always_ff @(posedge clk) begin
    if (en) begin
      row1 <= ({3'b000, row} > DIM_LAST) ? DIM_LAST[9:0] : row;
      col1 <= ({3'b000, col} > DIM_LAST) ? DIM_LAST[9:0] : col;
    end
  end

  // stage 2: index times step
  assign colx = 31'($signed({1'b0, col1}));
  assign rowx = 31'($signed({1'b0, row1}));
  assign stx  = 31'(cfg.step_x);
  assign sty  = 31'(cfg.step_y);

  always_ff @(posedge clk) begin
    if (en) begin
      px2 <= colx * stx;
      py2 <= rowx * sty;
    end
  end

  // stage 3: ray direction
  always_ff @(posedge clk) begin
    if (en) begin
      dx3 <= rsps_pkg::sat_q(32'(cfg.corner_x) + 32'(px2));
      dy3 <= rsps_pkg::sat_q(32'(cfg.corner_y) + 32'(py2));
    end
  end

  // stage 4: products for a, b, c
  assign ox  = rsps_pkg::sat_q(-32'(cfg.sphere_x));
  assign oy  = rsps_pkg::sat_q(-32'(cfg.sphere_y));
  assign oz  = rsps_pkg::sat_q(-32'(cfg.sphere_z));
  assign edx = 40'(dx3);
  assign edy = 40'(dy3);
  assign eox = 40'(ox);
  assign eoy = 40'(oy);
  assign eoz = 40'(oz);

  always_ff @(posedge clk) begin
    if (en) begin
      dxdx4 <= edx * edx;
      dydy4 <= edy * edy;
      dxox4 <= edx * eox;
      dyoy4 <= edy * eoy;
      oxox4 <= eox * eox;
      oyoy4 <= eoy * eoy;
      ozoz4 <= eoz * eoz;
      rr4   <= 38'(cfg.sphere_radius) * 38'(cfg.sphere_radius);
      oz4   <= oz;
      dy4   <= dy3;
    end
  end

  // stage 5: quadratic coefficients and squared length
  always_ff @(posedge clk) begin
    if (en) begin
      a5 <= rsps_pkg::sat_q(32'($signed(dxdx4[39:16])) + 32'($signed(dydy4[39:16]))
                            + rsps_pkg::ONE_S);
      b5 <= rsps_pkg::sat_q((32'($signed(dxox4[39:16])) + 32'($signed(dyoy4[39:16]))
                             - 32'(oz4)) * 32'sd2);
      c5 <= rsps_pkg::sat_q(32'($signed(oxox4[39:16])) + 32'($signed(oyoy4[39:16]))
                            + 32'($signed(ozoz4[39:16]))
                            - 32'($signed({1'b0, rr4[37:16]})));
      lsq5 <= $unsigned(dxdx4) + $unsigned(dydy4) + rsps_pkg::DZ_SQ;
      dy5  <= dy4;
    end
  end

  // stage 6: discriminant terms
  assign ea = 40'(a5);
  assign eb = 40'(b5);
  assign ec = 40'(c5);

  always_ff @(posedge clk) begin
    if (en) begin
      bbp6 <= eb * eb;
      acp6 <= ea * ec;
      lsq6 <= lsq5;
      dy6  <= dy5;
    end
  end

  // hit test, b*b against 4ac
  assign bbx = $signed({{2{bbp6[39]}}, bbp6[39:16]});
  assign fac = $signed({acp6[39:16], 2'b00});

  always_comb begin
    ray.hit = (bbx >= fac);
    ray.dy  = dy6;
    ray.lsq = lsq6;
  end

  assign push = v6 && en;

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

endmodule

// ===== sv/rsps_queue.sv =====
`timescale 1ns / 1ps
module rsps_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rsps_pkg::ray_t din,
  output logic           valid,
  output rsps_pkg::ray_t dout,
  output logic           full
);

  rsps_pkg::ray_t mem [0:1];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       pop;

  // the back end drains one entry every cycle
  assign valid = (cnt != 2'd0);
  assign pop   = valid;
  assign full  = (cnt == 2'd2);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/rsps_isqrt.sv =====
`timescale 1ns / 1ps
module rsps_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [rsps_pkg::LSQ_W-1:0]    in_val,
  input  rsps_pkg::tag_t                in_tag,
  output logic                          out_valid,
  output logic [rsps_pkg::LEN_W-1:0]    out_root,
  output rsps_pkg::tag_t                out_tag
);

  localparam int N = rsps_pkg::SQ_STG;

  logic [40:0]    sv [0:N];
  logic [40:0]    sr [0:N];
  logic           ok [0:N];
  rsps_pkg::tag_t st [0:N];

  assign sv[0] = 41'(in_val);
  assign sr[0] = 41'd0;
  assign ok[0] = in_valid;
  assign st[0] = in_tag;

  // one result bit per stage, bit weight falls by four each step
  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [40:0] BIT = 41'd1 << (38 - 2 * i);
    logic [40:0] trial;
    assign trial = sr[i] + BIT;

    always_ff @(posedge clk) begin
      if (sv[i] >= trial) begin
        sv[i+1] <= sv[i] - trial;
        sr[i+1] <= (sr[i] >> 1) + BIT;
      end else begin
        sv[i+1] <= sv[i];
        sr[i+1] <= sr[i] >> 1;
      end
      st[i+1] <= st[i];
    end

    always_ff @(posedge clk) begin
      if (rst) ok[i+1] <= 1'b0;
      else ok[i+1] <= ok[i];
    end
  end

  assign out_valid = ok[N];
  assign out_root  = sr[N][rsps_pkg::LEN_W-1:0];
  assign out_tag   = st[N];

endmodule

// ===== sv/rsps_div.sv =====
`timescale 1ns / 1ps
module rsps_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [rsps_pkg::LEN_W-1:0]    den,
  input  rsps_pkg::tag_t                in_tag,
  output logic                          out_valid,
  output logic [rsps_pkg::QUO_W-1:0]    quo,
  output rsps_pkg::tag_t                out_tag
);

  localparam int N = rsps_pkg::QUO_W;

  logic [36:0]             rem [0:N];
  logic [N-1:0]            qq  [0:N];
  logic [19:0]             dd  [0:N];
  logic                    ok  [0:N];
  rsps_pkg::tag_t          st  [0:N];

  // dividend is |dy| scaled by one; a zero length counts as one
  assign rem[0] = 37'({in_tag.mag, 16'h0000});
  assign qq[0]  = '0;
  assign dd[0]  = (den == '0) ? 20'd1 : den;
  assign ok[0]  = in_valid;
  assign st[0]  = in_tag;

  // restoring division, one quotient bit per stage from the top
  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int SH = N - 1 - i;
    logic [36:0] trial;
    assign trial = 37'(dd[i]) << SH;

    always_ff @(posedge clk) begin
      if (rem[i] >= trial) begin
        rem[i+1] <= rem[i] - trial;
        qq[i+1]  <= qq[i] | (N'(1) << SH);
      end else begin
        rem[i+1] <= rem[i];
        qq[i+1]  <= qq[i];
      end
      dd[i+1] <= dd[i];
      st[i+1] <= st[i];
    end

    always_ff @(posedge clk) begin
      if (rst) ok[i+1] <= 1'b0;
      else ok[i+1] <= ok[i];
    end
  end

  assign out_valid = ok[N];
  assign quo       = qq[N];
  assign out_tag   = st[N];

endmodule

// ===== sv/rsps_back.sv =====
`timescale 1ns / 1ps
module rsps_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  rsps_pkg::ray_t ray,
  output logic           done,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue,
  output logic           hit
);

  rsps_pkg::tag_t tag_in, sq_tag, dv_tag;
  logic           sq_ok, dv_ok;
  logic [rsps_pkg::LEN_W-1:0] len;
  logic [rsps_pkg::QUO_W-1:0] q;

  logic        c1, c2, c3, c4;
  logic        h1, h2, h3, h4;
  logic [16:0] qc;
  logic [17:0] t1;
  logic [16:0] rv2, rv3, gv3;
  logic [31:0] tk2;
  logic [41:0] pr4, pg4;

  // sign and magnitude of dy
  always_comb begin
    tag_in.hit = ray.hit;
    tag_in.neg = ray.dy[19];
    tag_in.mag = ray.dy[19] ? 20'(-ray.dy) : 20'(ray.dy);
  end

  rsps_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_val   (ray.lsq),
    .in_tag   (tag_in),
    .out_valid(sq_ok),
    .out_root (len),
    .out_tag  (sq_tag)
  );

  rsps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq_ok),
    .den      (len),
    .in_tag   (sq_tag),
    .out_valid(dv_ok),
    .quo      (q),
    .out_tag  (dv_tag)
  );

  assign qc = (q > rsps_pkg::ONE) ? rsps_pkg::ONE : q;

  // gradient: t, then red and green levels, then byte scaling
  always_ff @(posedge clk) begin
    t1  <= dv_tag.neg ? (18'(rsps_pkg::ONE) - 18'(qc)) >> 1
                      : (18'(rsps_pkg::ONE) + 18'(qc)) >> 1;
    h1  <= dv_tag.hit;
    rv2 <= rsps_pkg::ONE - 17'(t1 >> 1);
    tk2 <= 32'(t1) * 32'(rsps_pkg::K03);
    h2  <= h1;
    rv3 <= rv2;
    gv3 <= rsps_pkg::ONE - tk2[32-1:16];
    h3  <= h2;
    pr4 <= 42'(rv3) * 42'(rsps_pkg::SCALE);
    pg4 <= 42'(gv3) * 42'(rsps_pkg::SCALE);
    h4  <= h3;
  end

  // output register, hit pixels are pure red
  always_ff @(posedge clk) begin
    if (h4) begin
      red   <= 8'd255;
      green <= 8'd0;
      blue  <= 8'd0;
    end else begin
      red   <= (pr4[41:32] > 10'd255) ? 8'd255 : pr4[39:32];
      green <= (pg4[41:32] > 10'd255) ? 8'd255 : pg4[39:32];
      blue  <= 8'd255;
    end
    hit <= h4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1   <= 1'b0;
      c2   <= 1'b0;
      c3   <= 1'b0;
      c4   <= 1'b0;
      done <= 1'b0;
    end else begin
      c1   <= dv_ok;
      c2   <= c1;
      c3   <= c2;
      c4   <= c3;
      done <= c4;
    end
  end

endmodule

// ===== sv/ray_sphere_pixel_shader.sv =====
`timescale 1ns / 1ps
// channel   | ports                                   | transfer
// ----------+-----------------------------------------+-------------------------
// pixel in  | start, busy, row, col                   | start high, busy low
// result    | done, red, green, blue, hit             | done high, one cycle
// config    | cfg_we, cfg_index, cfg_data             | cfg_we high
//
// One pixel per cycle while busy is low. done rises after six front stages (the first
// loaded at the accepting edge), the queue, twenty square-root stages, seventeen
// divider stages and five shading stages.
// The divider and square-root pipelines set the depth; nothing iterates.
// Synchronous reset clears all valid flags and loads the default camera.
// The result side cannot stall, so the back end drains the queue every cycle
// and busy stays low in normal operation.
module ray_sphere_pixel_shader #(
  parameter int MAX_DIM = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  row,
  input  logic [9:0]  col,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output logic        done,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        hit
);

  rsps_pkg::cfg_t cfg;
  rsps_pkg::ray_t f_ray, q_ray;
  logic           f_push, q_valid, q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sphere_x      <= 20'sd0;
      cfg.sphere_y      <= 20'sd0;
      cfg.sphere_z      <= -20'sd65536;
      cfg.sphere_radius <= 19'd32768;
      cfg.corner_x      <= -20'sd116215;
      cfg.corner_y      <= 20'sd65245;
      cfg.step_x        <= 20'sd583;
      cfg.step_y        <= -20'sd583;
    end else if (cfg_we) begin
      case (rsps_pkg::reg_idx_t'(cfg_index))
        rsps_pkg::REG_SPHERE_X:      cfg.sphere_x      <= cfg_data;
        rsps_pkg::REG_SPHERE_Y:      cfg.sphere_y      <= cfg_data;
        rsps_pkg::REG_SPHERE_Z:      cfg.sphere_z      <= cfg_data;
        rsps_pkg::REG_SPHERE_RADIUS: cfg.sphere_radius <= cfg_data[18:0];
        rsps_pkg::REG_CORNER_X:      cfg.corner_x      <= cfg_data;
        rsps_pkg::REG_CORNER_Y:      cfg.corner_y      <= cfg_data;
        rsps_pkg::REG_STEP_X:        cfg.step_x        <= cfg_data;
        rsps_pkg::REG_STEP_Y:        cfg.step_y        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = q_full;

  rsps_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(start && !busy),
    .row     (row),
    .col     (col),
    .q_full  (q_full),
    .push    (f_push),
    .ray     (f_ray)
  );

  rsps_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (f_push),
    .din  (f_ray),
    .valid(q_valid),
    .dout (q_ray),
    .full (q_full)
  );

  rsps_back u_back (
    .clk     (clk),
    .rst     (rst),
    .in_valid(q_valid),
    .ray     (q_ray),
    .done    (done),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .hit     (hit)
  );

endmodule

// ===== test/ray_sphere_pixel_shader_tb.sv =====
`timescale 1ns / 1ps
module ray_sphere_pixel_shader_tb;

  localparam int LATENCY = 48;
  localparam int N_RAND  = 1600;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [9:0]  row = '0;
  logic [9:0]  col = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic        done;
  logic [7:0]  red, green, blue;
  logic        hit;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       hit;
  } pixel_t;

  pixel_t       colour_q[$];
  logic [19:0]  shadow[8];
  int           n_errors = 0;
  longint       cycles = 0;
  int           sender_idle = 0;

  ray_sphere_pixel_shader u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .row(row), .col(col),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .red(red), .green(green), .blue(blue), .hit(hit)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  function automatic longint clamp_q(input longint x);
    if (x > 524287) return 524287;
    if (x < -524288) return -524288;
    return x;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint root_floor(input longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [7:0] channel_byte(input longint v);
    longint sc, p;
    sc = (longint'(255999) << 16) / 1000;
    if (v < 0) v = 0;
    if (v > 65536) v = 65536;
    p = (v * sc) >> 32;
    return (p > 255) ? 8'd255 : p[7:0];
  endfunction

  // shade one pixel from the shadow registers
  function automatic pixel_t shade_pixel(input logic [9:0] r, input logic [9:0] c);
    pixel_t px;
    longint dx, dy, dz, ox, oy, oz, rad, a, b, cc, bb, fac;
    longint lsq, len, mag, q, u, t, rv, gv, k03;
    dx = clamp_q(longint'($signed(shadow[rsps_pkg::REG_CORNER_X]))
                 + longint'(c) * longint'($signed(shadow[rsps_pkg::REG_STEP_X])));
    dy = clamp_q(longint'($signed(shadow[rsps_pkg::REG_CORNER_Y]))
                 + longint'(r) * longint'($signed(shadow[rsps_pkg::REG_STEP_Y])));
    dz = -65536;
    ox = clamp_q(-longint'($signed(shadow[rsps_pkg::REG_SPHERE_X])));
    oy = clamp_q(-longint'($signed(shadow[rsps_pkg::REG_SPHERE_Y])));
    oz = clamp_q(-longint'($signed(shadow[rsps_pkg::REG_SPHERE_Z])));
    rad = longint'(shadow[rsps_pkg::REG_SPHERE_RADIUS][18:0]);
    a = clamp_q(qmul(dx, dx) + qmul(dy, dy) + qmul(dz, dz));
    b = clamp_q(2 * (qmul(dx, ox) + qmul(dy, oy) + qmul(dz, oz)));
    cc = clamp_q(qmul(ox, ox) + qmul(oy, oy) + qmul(oz, oz) - qmul(rad, rad));
    bb = qmul(b, b);
    fac = 4 * qmul(a, cc);
    if (bb >= fac) begin
      px = '{8'd255, 8'd0, 8'd0, 1'b1};
    end else begin
      lsq = dx * dx + dy * dy + dz * dz;
      len = root_floor(lsq);
      if (len == 0) len = 1;
      mag = (dy < 0) ? -dy : dy;
      q = (mag << 16) / len;
      if (q > 65536) q = 65536;
      u = (dy < 0) ? -q : q;
      t = (u + 65536) >> 1;
      k03 = (longint'(3) << 16) / 10;
      rv = 65536 - (t >> 1);
      gv = 65536 - ((t * k03) >> 16);
      px = '{channel_byte(rv), channel_byte(gv), channel_byte(65536), 1'b0};
    end
    return px;
  endfunction

  // result checker
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && done) begin
      if (colour_q.size() == 0) begin
        report("unexpected result", red, -1);
      end else begin
        want = colour_q.pop_front();
        if (red !== want.red) report("red", red, want.red);
        if (green !== want.green) report("green", green, want.green);
        if (blue !== want.blue) report("blue", blue, want.blue);
        if (hit !== want.hit) report("hit", hit, want.hit);
      end
    end
  end

  // one register write, then the write port goes idle before the task returns
  task automatic write_reg(input rsps_pkg::reg_idx_t idx, input logic [19:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow[idx] = (idx == rsps_pkg::REG_SPHERE_RADIUS) ? {1'b0, val[18:0]} : val;
    @(posedge clk);
  endtask

  // one pixel transfer, with sender gaps; start is left high for the next one
  task automatic send_pixel(input logic [9:0] r, input logic [9:0] c);
    while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    row <= r;
    col <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    colour_q.push_back(shade_pixel(r, c));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (colour_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  typedef struct {
    logic [9:0] r;
    logic [9:0] c;
    logic       fixed;
    pixel_t     px;
  } vec_t;

  vec_t vecs[$];

  initial begin
    pixel_t got;
    logic [19:0] v;
    vec_t e;
    shadow[rsps_pkg::REG_SPHERE_X] = 20'd0;
    shadow[rsps_pkg::REG_SPHERE_Y] = 20'd0;
    shadow[rsps_pkg::REG_SPHERE_Z] = 20'hF0000;
    shadow[rsps_pkg::REG_SPHERE_RADIUS] = 20'd32768;
    shadow[rsps_pkg::REG_CORNER_X] = 20'(-116215);
    shadow[rsps_pkg::REG_CORNER_Y] = 20'd65245;
    shadow[rsps_pkg::REG_STEP_X] = 20'd583;
    shadow[rsps_pkg::REG_STEP_Y] = 20'(-583);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: centre of default view is a hit
    vecs.push_back('{10'd112, 10'd199, 1'b1, '{8'd255, 8'd0, 8'd0, 1'b1}});
    vecs.push_back('{10'd0, 10'd0, 1'b0, '0});
    vecs.push_back('{10'd1023, 10'd1023, 1'b0, '0});
    vecs.push_back('{10'd0, 10'd1023, 1'b0, '0});
    vecs.push_back('{10'd1023, 10'd0, 1'b0, '0});
    vecs.push_back('{10'h155, 10'h2AA, 1'b0, '0});
    vecs.push_back('{10'h2AA, 10'h155, 1'b0, '0});
    foreach (vecs[i]) begin
      e = vecs[i];
      send_pixel(e.r, e.c);
      if (e.fixed) begin
        got = colour_q[$];
        if (got != e.px) report("table row", i, -1);
      end
    end
    drain();

    // extremes: huge steps saturate dx/dy; sphere far off misses
    write_reg(rsps_pkg::REG_STEP_X, 20'h7FFFF);
    write_reg(rsps_pkg::REG_STEP_Y, 20'h80000);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1, 10'd1);
    drain();
    write_reg(rsps_pkg::REG_SPHERE_X, 20'h7FFFF);
    write_reg(rsps_pkg::REG_SPHERE_Y, 20'h80000);
    write_reg(rsps_pkg::REG_SPHERE_RADIUS, 20'd0);
    write_reg(rsps_pkg::REG_CORNER_X, 20'h80000);
    write_reg(rsps_pkg::REG_CORNER_Y, 20'h7FFFF);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    drain();
    write_reg(rsps_pkg::REG_SPHERE_RADIUS, 20'h7FFFF);
    write_reg(rsps_pkg::REG_SPHERE_Z, 20'h80000);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd512, 10'd512);
    drain();

    // random phases: sender idles 16%, then 79%, then never
    for (int ph = 0; ph < 6; ph++) begin
      sender_idle = (ph < 2) ? 16 : (ph < 4) ? 79 : 0;
      for (int k = 0; k < 8; k++) begin
        v = $urandom;
        case ($urandom_range(3))
          0: v = v;
          1: v = {{4{v[19]}}, v[15:0]};
          2: v = {{8{v[19]}}, v[11:0]};
          default: v = {{12{v[19]}}, v[7:0]};
        endcase
        if (ph == 0 && k == 0) write_reg(rsps_pkg::REG_CORNER_Y, 20'h00000);
        write_reg(rsps_pkg::reg_idx_t'(k), v);
      end
      // keep a visible sphere in about half the phases
      if (ph[0]) begin
        write_reg(rsps_pkg::REG_SPHERE_Z, 20'(-65536 * ($urandom_range(3) + 1)));
        write_reg(rsps_pkg::REG_STEP_X, 20'($urandom_range(2000)) - 20'd1000);
        write_reg(rsps_pkg::REG_STEP_Y, 20'($urandom_range(2000)) - 20'd1000);
        write_reg(rsps_pkg::REG_CORNER_X, 20'($urandom_range(131072)) - 20'd65536);
        write_reg(rsps_pkg::REG_CORNER_Y, 20'($urandom_range(131072)) - 20'd65536);
      end
      for (int n = 0; n < N_RAND / 6; n++) begin
        if ($urandom_range(3) == 0) send_pixel(10'($urandom), 10'($urandom));
        else send_pixel(10'($urandom_range(255)), 10'($urandom_range(255)));
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
